// ===== src/fifo_with_delete_by_value_defines.svh =====
// ---------------------------------------------------------------------------
// fifo_with_delete_by_value_defines.svh
// Assertion macros for the handle FIFO with delete by value.
// ---------------------------------------------------------------------------
`ifndef FIFO_WITH_DELETE_BY_VALUE_DEFINES_SVH
`define FIFO_WITH_DELETE_BY_VALUE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// implication property, checked out of reset
`define FWDV_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition that must never hold
`define FWDV_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define FWDV_ASSERT(lbl, clk, rstn, prop, msg)
`define FWDV_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== src/fwdv_pkg.sv =====
// ---------------------------------------------------------------------------
// fwdv_pkg
// Shared types and constants for the handle FIFO with delete by value.
// ---------------------------------------------------------------------------
`default_nettype none

package fwdv_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int HANDLE_BITS_DEF = 32;
    localparam int VALUE_BITS      = 32;
    localparam int KIND_BITS       = 2;
    localparam int COUNT_OUT_BITS  = 5;

    localparam logic [KIND_BITS-1:0] KIND_ENQ = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_DEQ = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_DEL = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [VALUE_BITS-1:0] item_value;
    } req_t;

    typedef struct packed {
        logic                      status;
        logic [VALUE_BITS-1:0]     out_value;
        logic [COUNT_OUT_BITS-1:0] entry_count;
    } rsp_t;

endpackage

`default_nettype wire

// ===== src/fifo_with_delete_by_value.sv =====
// ---------------------------------------------------------------------------
// fifo_with_delete_by_value
// FIFO of nonzero handles with enqueue, dequeue and delete of the first
// matching handle; one result per request.
// ---------------------------------------------------------------------------
// One request is worked at a time; req_stall is high from acceptance until
// the result has been loaded into the output register. Enqueue and any error
// found at acceptance go from acceptance straight to the output state;
// dequeue first passes S_DEQ. Delete walks the store through its single
// read port: each entry is read and compared up to and including the match,
// then each later entry is read and written one slot toward the head.
// A result waiting in the output register does not block acceptance of the
// next request, but that request's result is held (with req_stall high) until
// the waiting transfer completes.
`default_nettype none

`include "fifo_with_delete_by_value_defines.svh"

module fifo_with_delete_by_value
    import fwdv_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEQ,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [IW-1:0]          head_reg, head_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [HANDLE_BITS-1:0] h_reg, h_next;
    rsp_t                   pend_reg, pend_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_t                   rsp_reg, rsp_next;

    // shared slot unit: (head + offset) mod DEPTH
    logic [CW-1:0]          off;
    logic [CW:0]            slot_sum;
    logic [IW-1:0]          slot;

    logic                   we;
    logic [HANDLE_BITS-1:0] wdata;
    logic [HANDLE_BITS-1:0] rdata;
    logic [HANDLE_BITS-1:0] req_h;
    logic                   empty;
    logic                   full;
    logic [CW-1:0]          idx_inc;

    function automatic rsp_t mk_rsp(input logic st, input logic [VALUE_BITS-1:0] v,
                                    input logic [CW-1:0] c);
        rsp_t r;
        r.status      = st;
        r.out_value   = v;
        r.entry_count = COUNT_OUT_BITS'(c);
        return r;
    endfunction

    fwdv_ram #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (slot),
        .wdata (wdata),
        .raddr (slot),
        .rdata (rdata)
    );

    assign req_h   = HANDLE_BITS'(req.item_value);
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign idx_inc = idx_reg + CW'(1);

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:     off = (req.kind == KIND_ENQ) ? count_reg : '0;
            S_DEQ:      off = CW'(1);
            S_SHIFT_RD: off = idx_inc;
            default:    off = idx_reg;
        endcase
    end

    assign slot_sum = (CW+1)'(head_reg) + (CW+1)'(off);
    assign slot     = (slot_sum >= (CW+1)'(DEPTH)) ? IW'(slot_sum - (CW+1)'(DEPTH))
                                                   : IW'(slot_sum);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        idx_next       = idx_reg;
        h_next         = h_reg;
        pend_next      = pend_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        we             = 1'b0;
        wdata          = h_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    h_next     = req_h;
                    idx_next   = '0;
                    state_next = S_OUT;
                    pend_next  = mk_rsp(STATUS_ERR, '0, count_reg);
                    case (req.kind)
                        KIND_ENQ:
                        begin
                            if (req_h != '0 && !full)
                            begin
                                we         = 1'b1;
                                wdata      = req_h;
                                count_next = count_reg + CW'(1);
                                pend_next  = mk_rsp(STATUS_OK, '0, count_reg + CW'(1));
                            end
                        end
                        KIND_DEQ:
                        begin
                            if (!empty)
                            begin
                                state_next = S_DEQ;
                            end
                        end
                        KIND_DEL:
                        begin
                            // read of the oldest slot is already issued
                            if (!empty && req_h != '0)
                            begin
                                state_next = S_SCAN_CMP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DEQ:
            begin
                head_next  = slot;
                count_next = count_reg - CW'(1);
                pend_next  = mk_rsp(STATUS_OK, VALUE_BITS'(rdata), count_reg - CW'(1));
                state_next = S_OUT;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (rdata == h_reg)
                begin
                    if (idx_inc < count_reg)
                    begin
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        if (count_reg == CW'(1))
                        begin
                            head_next = '0;
                        end
                        pend_next  = mk_rsp(STATUS_OK, '0, count_reg - CW'(1));
                        state_next = S_OUT;
                    end
                end
                else if (idx_inc < count_reg)
                begin
                    idx_next   = idx_inc;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    pend_next  = mk_rsp(STATUS_ERR, '0, count_reg);
                    state_next = S_OUT;
                end
            end
            S_SHIFT_RD:
            begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                we       = 1'b1;
                wdata    = rdata;
                idx_next = idx_inc;
                if (idx_inc + CW'(1) < count_reg)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    // the match was never the only entry here
                    count_next = count_reg - CW'(1);
                    pend_next  = mk_rsp(STATUS_OK, '0, count_reg - CW'(1));
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = pend_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        h_reg    <= h_next;
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `FWDV_NEVER(a_count_range, clk, rst_n, count_reg > CW'(DEPTH), "entry count above depth")
    `FWDV_ASSERT(a_err_zero_value, clk, rst_n,
                 (rsp_valid && rsp.status == STATUS_ERR) |-> (rsp.out_value == '0),
                 "error result carries a value")
    `FWDV_ASSERT(a_count_step, clk, rst_n,
                 !$stable(count_reg) |-> (count_reg == $past(count_reg) + CW'(1) ||
                                          count_reg + CW'(1) == $past(count_reg)),
                 "entry count moved by more than one")
    `FWDV_ASSERT(a_one_result, clk, rst_n,
                 (state_reg == S_OUT && state_next == S_IDLE) |=> rsp_valid,
                 "loaded result not presented")

endmodule

`default_nettype wire

// ===== src/fwdv_ram.sv =====
// ---------------------------------------------------------------------------
// fwdv_ram
// Handle store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module fwdv_ram
    import fwdv_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF,
    localparam int IW         = $clog2(DEPTH)
)
(
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [IW-1:0]          waddr,
    input  wire logic [HANDLE_BITS-1:0] wdata,
    input  wire logic [IW-1:0]          raddr,
    output logic      [HANDLE_BITS-1:0] rdata
);

    logic [HANDLE_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== tb/fifo_result_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fifo_result_checker
// Watches the request and response channels of the handle FIFO, keeps its
// own image of the store, predicts one response per accepted request and
// compares every accepted response field by field.
// ---------------------------------------------------------------------------
module fifo_result_checker
    import fwdv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   fail_count,
    output int   pending,
    output int   checked_count,
    output int   reject_count,
    output int   peak_fill
);

    logic [VALUE_BITS-1:0] held_handles [DEPTH_DEF];
    int   head_slot;
    int   held;
    rsp_t awaited_rsp [$];

    initial begin
        fail_count    = 0;
        checked_count = 0;
        reject_count  = 0;
        peak_fill     = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("[%0t] mismatch %0d: %s got %0h expected %0h",
                 $realtime, fail_count, what, got, want);
    endtask

    // Applies one operation to the store image and returns its response.
    function automatic rsp_t apply_handle_op(input req_t op);
        rsp_t r;
        int   pos;
        int   j;
        r.status    = STATUS_ERR;
        r.out_value = '0;
        case (op.kind)
            KIND_ENQ:
            begin
                if (op.item_value != '0 && held < DEPTH_DEF)
                begin
                    held_handles[(head_slot + held) % DEPTH_DEF] = op.item_value;
                    held++;
                    r.status = STATUS_OK;
                end
            end
            KIND_DEQ:
            begin
                if (held != 0)
                begin
                    r.out_value = held_handles[head_slot];
                    head_slot   = (head_slot + 1) % DEPTH_DEF;
                    held--;
                    r.status = STATUS_OK;
                end
            end
            KIND_DEL:
            begin
                if (held != 0 && op.item_value != '0)
                begin
                    pos = 0;
                    while (pos < held &&
                           held_handles[(head_slot + pos) % DEPTH_DEF] != op.item_value)
                        pos++;
                    if (pos < held)
                    begin
                        // close the gap so arrival order is kept
                        for (j = pos; j + 1 < held; j++)
                            held_handles[(head_slot + j) % DEPTH_DEF] =
                                held_handles[(head_slot + j + 1) % DEPTH_DEF];
                        held--;
                        if (held == 0)
                            head_slot = 0;
                        r.status = STATUS_OK;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.entry_count = held[COUNT_OUT_BITS-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            head_slot = 0;
            held      = 0;
            awaited_rsp.delete();
            pending <= 0;
        end
        else
        begin
            // a response never belongs to the request accepted on the same edge
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsp.size() == 0)
                    report_mismatch("response with nothing outstanding",
                                    rsp.out_value, '0);
                else
                begin
                    want = awaited_rsp.pop_front();
                    checked_count++;
                    if (want.status == STATUS_ERR)
                        reject_count++;
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.out_value !== want.out_value)
                        report_mismatch("out_value", rsp.out_value, want.out_value);
                    if (rsp.entry_count !== want.entry_count)
                        report_mismatch("entry_count", rsp.entry_count,
                                        want.entry_count);
                end
            end
            if (req_valid && !req_stall)
            begin
                awaited_rsp.push_back(apply_handle_op(req));
                if (held > peak_fill)
                    peak_fill = held;
            end
            pending <= awaited_rsp.size();
        end
    end

endmodule

// ===== tb/fifo_with_delete_by_value_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fifo_with_delete_by_value_tb
// Drives enqueue, dequeue and delete traffic into the handle FIFO with
// random idle bursts on both channels; a checker beside the block predicts
// and compares every response.
// ---------------------------------------------------------------------------
module fifo_with_delete_by_value_tb;
    import fwdv_pkg::*;

    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_OPS = 1850;
    localparam int STEADY_OPS = 200;
    localparam int BLOCK_OPS  = 50;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    int fail_count;
    int pending;
    int checked_count;
    int reject_count;
    int peak_fill;

    bit sender_jitter;
    bit receiver_jitter;
    bit filling;
    logic [VALUE_BITS-1:0] handle_pool [12];

    fifo_with_delete_by_value dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    fifo_result_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .reject_count  (reject_count),
        .peak_fill     (peak_fill)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d responses outstanding", pending);
        $display("FAILED: results differ");
        $finish;
    end

    // response side: stall bursts and free-running stretches
    initial
    begin : rsp_pacing
        int run;
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = $urandom_range(1, 18);
            if (receiver_jitter && $urandom_range(0, 1) == 1)
                rsp_stall <= 1'b1;
            else
                rsp_stall <= 1'b0;
            repeat (run) @(posedge clk);
        end
    end

    // One request transfer, optionally after an idle burst.
    task automatic issue(input logic [KIND_BITS-1:0] kind,
                         input logic [VALUE_BITS-1:0] value);
        int gap;
        if (sender_jitter && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{kind: kind, item_value: value};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic drain_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Mostly handles from a small pool so deletes find matches and duplicates.
    function automatic logic [VALUE_BITS-1:0] pick_handle();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            return '0;
        else if (sel < 20)
            return $urandom;
        else
            return handle_pool[$urandom_range(0, 11)];
    endfunction

    function automatic logic [KIND_BITS-1:0] pick_kind();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 4)
            return KIND_UNUSED;
        if (filling)
            return (sel < 58) ? KIND_ENQ : (sel < 74) ? KIND_DEQ : KIND_DEL;
        return (sel < 30) ? KIND_ENQ : (sel < 68) ? KIND_DEQ : KIND_DEL;
    endfunction

    initial
    begin : stimulus
        int i;
        int k;
        int drain_wait;
        rst_n           <= 1'b0;
        req_valid       <= 1'b0;
        req             <= '0;
        sender_jitter   = 1'b0;
        receiver_jitter = 1'b0;
        filling         = 1'b1;
        foreach (handle_pool[p])
            handle_pool[p] = $urandom | 32'h1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // errors on an empty store
        issue(KIND_DEQ, 32'h0);
        issue(KIND_DEL, 32'h1);
        issue(KIND_UNUSED, 32'hFFFF_FFFF);
        issue(KIND_ENQ, 32'h0);
        // delete from a single-entry store
        issue(KIND_ENQ, 32'hFFFF_FFFF);
        issue(KIND_DEL, 32'hFFFF_FFFF);
        // duplicates, then fill to the top
        issue(KIND_ENQ, 32'h0000_0001);
        issue(KIND_ENQ, 32'h8000_0000);
        issue(KIND_ENQ, 32'h0000_0001);
        for (k = 3; k < DEPTH_DEF; k++)
            issue(KIND_ENQ, (k << 8) | k);
        issue(KIND_ENQ, 32'h0000_0042);
        issue(KIND_DEL, 32'h0000_0001);
        issue(KIND_DEL, 32'h0);
        issue(KIND_DEL, 32'h5A5A_5A5A);
        issue(KIND_DEL, ((DEPTH_DEF - 1) << 8) | (DEPTH_DEF - 1));
        issue(KIND_DEQ, 32'h0);
        drain_responses();

        for (i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % BLOCK_OPS == 0)
            begin
                filling = $urandom_range(0, 1);
                sender_jitter   = (i < RANDOM_OPS - STEADY_OPS) && $urandom_range(0, 2) != 0;
                receiver_jitter = (i < RANDOM_OPS - STEADY_OPS) && $urandom_range(0, 2) != 0;
                handle_pool[$urandom_range(0, 11)] = $urandom;
                handle_pool[$urandom_range(0, 11)] = $urandom;
            end
            if (i > 0 && i % 400 == 0)
                drain_responses();
            issue(pick_kind(), pick_handle());
        end

        sender_jitter   = 1'b0;
        receiver_jitter = 1'b0;
        req_valid <= 1'b0;
        @(posedge clk);
        drain_wait = 0;
        while (pending != 0 && drain_wait < 5000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (40) @(posedge clk);

        $display("Covered: %0d responses checked, %0d of them rejected operations,",
                 checked_count, reject_count);
        $display("store fill reached %0d of %0d entries.", peak_fill, DEPTH_DEF);
        if (pending != 0)
            $display("%0d responses never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
